@@ hw/rtl/sat_pkg.sv @@
// Shared types and constants for the section address translator.
// Used by the translator top level and its port checker.
// No dependencies.
`default_nettype none

package sat_pkg;

   // Section table depth
   localparam int MAX_SECTIONS = 16;

   // Field widths
   localparam int ADDR_W      = 32;
   localparam int COMMAND_W   = 2;
   localparam int SECT_IDX_W  = 4;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 4;

   // Command codes on the request channel
   typedef enum logic [COMMAND_W-1:0] {
      CMD_LOAD         = 2'd0,
      CMD_FROM_VIRTUAL = 2'd1,
      CMD_FROM_RVA     = 2'd2,
      CMD_FROM_OFFSET  = 2'd3
   } command_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_CONVERTED  = 2'd0,
      ST_OFF_RANGE  = 2'd1,
      ST_NO_MATCH   = 2'd2,
      ST_UNUSED     = 2'd3
   } status_type;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BASE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION_COUNT = 4'd1;

   localparam logic [ADDR_W-1:0] IMAGE_BASE_RESET = 32'h0040_0000;
   localparam logic [ADDR_W-1:0] ALL_ONES         = {ADDR_W{1'b1}};

endpackage : sat_pkg

`default_nettype wire

@@ hw/rtl/section_address_translator.sv @@
// Section address translator: section table plus five-stage convert pipeline.
// Depends on sat_pkg.
//
// Usage:
//   Request channel: an item transfers on a rising edge with start high and
//   busy low. Command LOAD writes one section table entry and gives no
//   result; the three convert commands give exactly one result each.
//   Configuration channel: csr_valid/csr_ready with csr_index and csr_wdata;
//   index 0 is the image base, index 1 the section count, others are ignored.
//   Write registers only while no convert is in flight.
//   Response channel: rsp_strobe marks one cycle of result data; the
//   receiver takes it in that cycle and cannot stall the block.
// Throughput and ordering:
//   One request per cycle while busy is low, back to back, loads and converts mixed.
//   A convert passes the input register, parallel compare of the entries
//   below the section count, first-match select, offset adder, range check
//   and output register. Results leave in request order.
//   Table writes happen in the compare stage, so each convert sees exactly
//   the loads that were transferred before it.
// Reset:
//   Clears all stage valid bits and loads the register reset values; busy
//   is high for the cycle after reset. Table contents are undefined until
//   loaded.
`default_nettype none

module section_address_translator
   import sat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [COMMAND_W-1:0]   req_command,
   input  wire logic [ADDR_W-1:0]      req_address,
   input  wire logic [SECT_IDX_W-1:0]  req_section_index,
   input  wire logic [ADDR_W-1:0]      req_entry_virtual_start,
   input  wire logic [ADDR_W-1:0]      req_entry_virtual_size,
   input  wire logic [ADDR_W-1:0]      req_entry_raw_start,
   input  wire logic [ADDR_W-1:0]      req_entry_raw_size,
   // configuration channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]      csr_wdata,
   // response channel
   output logic                        rsp_strobe,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [ADDR_W-1:0]           rsp_virtual_address,
   output logic [ADDR_W-1:0]           rsp_relative_address,
   output logic [ADDR_W-1:0]           rsp_file_offset,
   output logic                        rsp_file_offset_valid
);

   // ---------------------------------------------------------------
   // Control and configuration registers
   // ---------------------------------------------------------------
   logic                   busy_ff;
   logic [ADDR_W-1:0]      image_base_ff, image_base_in;
   logic [COUNT_W-1:0]     section_count_ff, section_count_in;
   logic                   accept;
   logic                   csr_write;

   assign accept    = start & ~busy_ff;
   assign csr_write = csr_valid & csr_ready;
   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   always_comb begin
      image_base_in    = image_base_ff;
      section_count_in = section_count_ff;
      if (csr_write && csr_index == CSR_IMAGE_BASE) begin
         image_base_in = csr_wdata;
      end
      if (csr_write && csr_index == CSR_SECTION_COUNT) begin
         section_count_in = csr_wdata[COUNT_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: input register; rva/va forms and entry end sums
   // ---------------------------------------------------------------
   logic                   v1_ff;
   command_type            cmd1_ff;
   logic [ADDR_W-1:0]      key1_ff, key1_in;     // rva, or file offset for CMD_FROM_OFFSET
   logic [ADDR_W-1:0]      va1_ff, va1_in;
   logic [SECT_IDX_W-1:0]  ld_idx_ff;
   logic [ADDR_W-1:0]      ld_vs_ff, ld_vend_ff, ld_rs_ff, ld_rend_ff;

   always_comb begin
      key1_in = req_address;
      va1_in  = req_address + image_base_ff;
      if (command_type'(req_command) == CMD_FROM_VIRTUAL) begin
         key1_in = req_address - image_base_ff;
         va1_in  = req_address;
      end
   end

   // ---------------------------------------------------------------
   // Section table (start and end of each range); written by loads in stage 1
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] tbl_vs_ff   [MAX_SECTIONS];
   logic [ADDR_W-1:0] tbl_vend_ff [MAX_SECTIONS];
   logic [ADDR_W-1:0] tbl_rs_ff   [MAX_SECTIONS];
   logic [ADDR_W-1:0] tbl_rend_ff [MAX_SECTIONS];

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         if (v1_ff && cmd1_ff == CMD_LOAD && int'(ld_idx_ff) == i) begin
            tbl_vs_ff[i]   <= ld_vs_ff;
            tbl_vend_ff[i] <= ld_vend_ff;
            tbl_rs_ff[i]   <= ld_rs_ff;
            tbl_rend_ff[i] <= ld_rend_ff;
         end
      end
   end

   // Stage 1 compare: every active entry against the key, in parallel
   logic [MAX_SECTIONS-1:0] hit2_in;

   always_comb begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         logic ge_vs, le_vs, le_vend, ge_rs, le_rend, nonneg;
         ge_vs   = $signed(key1_ff) >= $signed(tbl_vs_ff[i]);
         le_vs   = $signed(key1_ff) <= $signed(tbl_vs_ff[i]);
         le_vend = $signed(key1_ff) <= $signed(tbl_vend_ff[i]);
         ge_rs   = $signed(key1_ff) >= $signed(tbl_rs_ff[i]);
         le_rend = $signed(key1_ff) <= $signed(tbl_rend_ff[i]);
         nonneg  = ~key1_ff[ADDR_W-1];
         case (cmd1_ff)
            CMD_FROM_VIRTUAL: hit2_in[i] = (ge_vs & le_vend) | (nonneg & le_vs);
            CMD_FROM_RVA:     hit2_in[i] = nonneg & le_vend;
            CMD_FROM_OFFSET:  hit2_in[i] = ge_rs & le_rend;
            default:          hit2_in[i] = 1'b0;
         endcase
         // entries at or above the section count are not searched
         if (int'(section_count_ff) <= i) begin
            hit2_in[i] = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: pick the first matching entry, read its fields
   // ---------------------------------------------------------------
   logic                    v2_ff;
   command_type             cmd2_ff;
   logic [ADDR_W-1:0]       key2_ff, va2_ff;
   logic [MAX_SECTIONS-1:0] hit2_ff;
   logic [MAX_SECTIONS-1:0] first2;
   logic [ADDR_W-1:0]       sel_vs_in, sel_rs_in, sel_rend_in;
   logic                    any3_in;

   always_comb begin
      first2      = hit2_ff & (~hit2_ff + MAX_SECTIONS'(1));
      any3_in     = |hit2_ff;
      sel_vs_in   = '0;
      sel_rs_in   = '0;
      sel_rend_in = '0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         sel_vs_in   = sel_vs_in   | ({ADDR_W{first2[i]}} & tbl_vs_ff[i]);
         sel_rs_in   = sel_rs_in   | ({ADDR_W{first2[i]}} & tbl_rs_ff[i]);
         sel_rend_in = sel_rend_in | ({ADDR_W{first2[i]}} & tbl_rend_ff[i]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: rebase the key into the other address space
   // ---------------------------------------------------------------
   logic              v3_ff;
   command_type       cmd3_ff;
   logic [ADDR_W-1:0] key3_ff, va3_ff;
   logic              any3_ff;
   logic [ADDR_W-1:0] vs3_ff, rs3_ff, rend3_ff;
   logic [ADDR_W-1:0] other4_in;

   // offset form: key - vs + rs; virtual form from offset: key - rs + vs
   always_comb begin
      if (cmd3_ff == CMD_FROM_OFFSET) begin
         other4_in = key3_ff - rs3_ff + vs3_ff;
      end else begin
         other4_in = key3_ff - vs3_ff + rs3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: raw data bound check and result forming
   // ---------------------------------------------------------------
   logic              v4_ff;
   command_type       cmd4_ff;
   logic [ADDR_W-1:0] key4_ff, va4_ff, other4_ff, rend4_ff;
   logic              any4_ff;

   status_type        status5_in;
   logic [ADDR_W-1:0] va5_in, rva5_in, fo5_in;
   logic              fo_ok5_in;

   always_comb begin
      status5_in = ST_CONVERTED;
      va5_in     = va4_ff;
      rva5_in    = key4_ff;
      fo5_in     = other4_ff;
      fo_ok5_in  = 1'b1;
      if (!any4_ff) begin
         status5_in = ST_NO_MATCH;
         va5_in     = '0;
         rva5_in    = '0;
         fo5_in     = ALL_ONES;
         fo_ok5_in  = 1'b0;
      end else if (cmd4_ff == CMD_FROM_OFFSET) begin
         va5_in  = other4_ff + image_base_ff;
         rva5_in = other4_ff;
         fo5_in  = key4_ff;
      end else if (other4_ff >= rend4_ff) begin
         // unsigned bound on the section's raw data
         status5_in = ST_OFF_RANGE;
         fo5_in     = ALL_ONES;
         fo_ok5_in  = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: output register
   // ---------------------------------------------------------------
   logic              v5_ff;
   status_type        status5_ff;
   logic [ADDR_W-1:0] va5_ff, rva5_ff, fo5_ff;
   logic              fo_ok5_ff;

   assign rsp_strobe            = v5_ff;
   assign rsp_status            = status5_ff;
   assign rsp_virtual_address   = va5_ff;
   assign rsp_relative_address  = rva5_ff;
   assign rsp_file_offset       = fo5_ff;
   assign rsp_file_offset_valid = fo_ok5_ff;

   // Control registers and stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b1;
         image_base_ff    <= IMAGE_BASE_RESET;
         section_count_ff <= '0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         v4_ff            <= 1'b0;
         v5_ff            <= 1'b0;
      end else begin
         busy_ff          <= 1'b0;
         image_base_ff    <= image_base_in;
         section_count_ff <= section_count_in;
         v1_ff            <= accept;
         v2_ff            <= v1_ff & (cmd1_ff != CMD_LOAD);
         v3_ff            <= v2_ff;
         v4_ff            <= v3_ff;
         v5_ff            <= v4_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd1_ff    <= command_type'(req_command);
      key1_ff    <= key1_in;
      va1_ff     <= va1_in;
      ld_idx_ff  <= req_section_index;
      ld_vs_ff   <= req_entry_virtual_start;
      ld_vend_ff <= req_entry_virtual_start + req_entry_virtual_size;
      ld_rs_ff   <= req_entry_raw_start;
      ld_rend_ff <= req_entry_raw_start + req_entry_raw_size;

      cmd2_ff    <= cmd1_ff;
      key2_ff    <= key1_ff;
      va2_ff     <= va1_ff;
      hit2_ff    <= hit2_in;

      cmd3_ff    <= cmd2_ff;
      key3_ff    <= key2_ff;
      va3_ff     <= va2_ff;
      any3_ff    <= any3_in;
      vs3_ff     <= sel_vs_in;
      rs3_ff     <= sel_rs_in;
      rend3_ff   <= sel_rend_in;

      cmd4_ff    <= cmd3_ff;
      key4_ff    <= key3_ff;
      va4_ff     <= va3_ff;
      any4_ff    <= any3_ff;
      other4_ff  <= other4_in;
      rend4_ff   <= rend3_ff;

      status5_ff <= status5_in;
      va5_ff     <= va5_in;
      rva5_ff    <= rva5_in;
      fo5_ff     <= fo5_in;
      fo_ok5_ff  <= fo_ok5_in;
   end

endmodule : section_address_translator

`default_nettype wire

@@ hw/rtl/sat_checker.sv @@
// Port-level checker for the section address translator, bound to the top level.
// Depends on sat_pkg and section_address_translator.
`default_nettype none

module sat_checker
   import sat_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic [COMMAND_W-1:0]   req_command,
   input wire logic                   rsp_strobe,
   input wire logic [STATUS_W-1:0]    rsp_status,
   input wire logic [ADDR_W-1:0]      rsp_virtual_address,
   input wire logic [ADDR_W-1:0]      rsp_relative_address,
   input wire logic [ADDR_W-1:0]      rsp_file_offset,
   input wire logic                   rsp_file_offset_valid
);

   // every result traces back to an earlier convert transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_command != CMD_LOAD, 5))
      else $error("result without a matching convert transfer");

   // offset valid flag agrees with the status
   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_file_offset_valid == (rsp_status == ST_CONVERTED)))
      else $error("file offset valid flag disagrees with status");

   // an invalid offset reads as all ones
   a_bad_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_file_offset_valid) |-> rsp_file_offset == ALL_ONES)
      else $error("invalid file offset is not all ones");

   // no match clears both address forms
   a_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NO_MATCH)
         |-> (rsp_virtual_address == '0 && rsp_relative_address == '0))
      else $error("no-match result carries nonzero addresses");

endmodule : sat_checker

bind section_address_translator sat_checker u_sat_checker (.*);

`default_nettype wire
